// ----- rtl/core/cmdim_pkg.sv -----
// Shared types and constants of the color mask, dilate and dim pixel block.
package cmdim_pkg;

  // Item field widths.
  localparam int CHAN_W    = 8;
  localparam int RGB_W     = 3 * CHAN_W;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // Register reset values.
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;
  localparam logic [CHAN_W-1:0] RED_FLOOR_RST   = 8'd100;
  localparam logic [CHAN_W-1:0] GREEN_FLOOR_RST = 8'd80;

  // Dimming to floor(3c/10) as a multiply by a scaled reciprocal.
  localparam int DIM_PROD_W = 18;
  localparam logic [DIM_PROD_W-1:0] DIM_MUL = 18'd615;
  localparam int DIM_SHIFT = 11;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_RED_FLOOR    = 2'd2,
    CFG_GREEN_FLOOR  = 2'd3
  } cfg_idx_e;

  // Window information handed from the address stage to the evaluation stage.
  typedef struct packed {
    logic [2:0]       col_ok;     // neighbor column interior, left to right
    logic [2:0]       row_ok;     // neighbor row interior, top to bottom
    logic [2:0]       bot;        // bottom row raw bits, already gated
    logic             bypass;     // oldest item is the newest one
    logic             byp_own;
    logic             byp_left;
    logic [RGB_W-1:0] byp_color;
    logic             frame_end;
  } win_t;

endpackage

// ----- rtl/core/cmdim_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module cmdim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/color_mask_dilate_dim_pixels.sv -----
// Top level of the color mask, 3x3 dilation and background dimming pixel block.
//
// The block takes raster-order RGB pixels, one item per clock, and marks each one
// fruit colored when it passes either the red test (2r > 3g, 2r > 3b, r above the
// red floor) or the green test (5g > 6r, 5g > 6b, g above the green floor). The
// mask is dilated over a 3x3 window, where only interior pixels of the frame spread
// their bit; every pixel keeps its own bit. Pixels outside the dilated mask leave
// with each component scaled to floor(3c/10). A result leaves once the pixel that
// completes its window has arrived, that is frame_width + 1 items later, so the
// last pixels of a stream are pushed out with drain items (tuser high), one result
// per drain; a drain with nothing pending produces no result. The block sustains
// one item per clock: the accepting edge reads the two line memories, the next
// cycle builds the window and the dimmed pixel, and the output register presents
// it. Input ready drops only while the evaluation stage is full and the output is
// stalled. One memory holds colors together with the local mask bits of the
// current line, the other the mask bits one line back; neither needs a clearing
// pass after reset. Configuration is written through a simple write port; the user
// must write it only while no item is in flight, which the block does not enforce.
module color_mask_dilate_dim_pixels #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port.
  input  logic                                  cfg_we_i,
  input  logic [cmdim_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [cmdim_pkg::CFG_W-1:0]           cfg_data_i,
  // Input stream.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [cmdim_pkg::RGB_W-1:0]           s_axis_tdata,  // red, green, blue
  input  logic                                  s_axis_tuser,  // op
  // Output stream.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [cmdim_pkg::RGB_W-1:0]           m_axis_tdata,  // out_red, out_green, out_blue
  output logic                                  m_axis_tuser,  // in_mask
  output logic                                  m_axis_tlast   // frame_end
);

  import cmdim_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int XW  = $clog2(MAX_WIDTH + 4);
  localparam int YW  = $clog2(MAX_HEIGHT + 4);
  localparam int PW  = $clog2(MAX_WIDTH + 3);
  localparam int A_DEPTH = 1 << $clog2(MAX_WIDTH + 2);
  localparam int T_DEPTH = 1 << $clog2(2 * MAX_WIDTH + 2);
  localparam int AAW = $clog2(A_DEPTH);
  localparam int TAW = $clog2(T_DEPTH);
  localparam int A_W = RGB_W + 3;
  localparam int WIDTH_RST  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int HEIGHT_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  function automatic logic [CHAN_W-1:0] dim_chan(input logic [CHAN_W-1:0] c);
    logic [DIM_PROD_W-1:0] prod;
    prod = DIM_PROD_W'(c) * DIM_MUL;
    return CHAN_W'(prod >> DIM_SHIFT);
  endfunction

  // Configuration registers; sizes are stored already clamped to their legal range.
  logic [WW-1:0]     width_q;
  logic [HW-1:0]     height_q;
  logic [CHAN_W-1:0] red_floor_q, green_floor_q;
  logic [WW-1:0]     width_clamp;
  logic [HW-1:0]     height_clamp;

  always_comb begin
    if (cfg_data_i == '0) begin
      width_clamp  = WW'(1);
      height_clamp = HW'(1);
    end else begin
      width_clamp  = (32'(cfg_data_i) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(cfg_data_i);
      height_clamp = (32'(cfg_data_i) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= WW'(WIDTH_RST);
      height_q      <= HW'(HEIGHT_RST);
      red_floor_q   <= RED_FLOOR_RST;
      green_floor_q <= GREEN_FLOOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_FRAME_WIDTH:  width_q       <= width_clamp;
        CFG_FRAME_HEIGHT: height_q      <= height_clamp;
        CFG_RED_FLOOR:    red_floor_q   <= cfg_data_i[CHAN_W-1:0];
        CFG_GREEN_FLOOR:  green_floor_q <= cfg_data_i[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv;
  logic accept, is_pixel, emit;

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_pixel      = (op_e'(s_axis_tuser) == OP_PIXEL);

  // Raw fruit-color test of the incoming pixel.
  logic [CHAN_W-1:0] in_r, in_g, in_b;
  logic              red_ok, green_ok, raw_new;

  assign in_r = s_axis_tdata[CHAN_W-1:0];
  assign in_g = s_axis_tdata[2*CHAN_W-1:CHAN_W];
  assign in_b = s_axis_tdata[3*CHAN_W-1:2*CHAN_W];

  always_comb begin
    red_ok   = ((10'(in_r) << 1) > (10'(in_g) * 10'd3)) &&
               ((10'(in_r) << 1) > (10'(in_b) * 10'd3)) &&
               (in_r > red_floor_q);
    green_ok = ((11'(in_g) * 11'd5) > (11'(in_r) * 11'd6)) &&
               ((11'(in_g) * 11'd5) > (11'(in_b) * 11'd6)) &&
               (in_g > green_floor_q);
    raw_new  = red_ok || green_ok;
  end

  // Stream state: write pointer, pending count, output position, recent pixels.
  logic [TAW-1:0]   wr_ptr_q;
  logic [PW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    ox_q, ox_d;
  logic [RW-1:0]    oy_q, oy_d;
  logic [2:0]       hist_q;        // raw bits of the newest pixels, newest in bit 0
  logic [RGB_W-1:0] color_last_q;  // color of the newest pixel

  logic [XW-1:0] w_x, ox_x, p_x, col_inc;
  logic [YW-1:0] h_y, oy_y, row_inc;
  logic [2:0]    post;
  logic          eq2, eq1, eq0;
  win_t          win_d, s1_win_q;

  always_comb begin
    w_x  = XW'(width_q);
    h_y  = YW'(height_q);
    ox_x = XW'(ox_q);
    oy_y = YW'(oy_q);
    // Pending count including the current pixel, if it is one.
    p_x  = XW'(cnt_q) + XW'(is_pixel);
    emit = is_pixel ? (XW'(cnt_q) > w_x) : (cnt_q != '0);

    cnt_d = cnt_q;
    if (accept) begin
      if (is_pixel && !emit) begin
        cnt_d = cnt_q + PW'(1);
      end else if (!is_pixel && emit) begin
        cnt_d = cnt_q - PW'(1);
      end
    end

    col_inc = ox_x + XW'(1);
    row_inc = oy_y + YW'(1);
    ox_d = ox_q;
    oy_d = oy_q;
    if (accept && emit) begin
      if (col_inc >= w_x) begin
        ox_d = '0;
        oy_d = (row_inc >= h_y) ? '0 : RW'(row_inc);
      end else begin
        ox_d = CW'(col_inc);
      end
    end

    // The bottom row of the window always lies among the three newest pixels;
    // its position relative to the newest one follows from the pending count.
    post = is_pixel ? {hist_q[1:0], raw_new} : hist_q;
    eq2  = (p_x == w_x + XW'(2));
    eq1  = (p_x == w_x + XW'(1));
    eq0  = (p_x == w_x);

    win_d.bot[0] = eq2 ? post[2] : eq1 ? post[1] : eq0 ? post[0] : 1'b0;
    win_d.bot[1] = eq2 ? post[1] : eq1 ? post[0] : 1'b0;
    win_d.bot[2] = eq2 ? post[0] : 1'b0;

    win_d.col_ok[0] = (ox_x >= XW'(2)) && (ox_x + XW'(1) <= w_x);
    win_d.col_ok[1] = (ox_x >= XW'(1)) && (ox_x + XW'(2) <= w_x);
    win_d.col_ok[2] = (ox_x + XW'(3) <= w_x);
    win_d.row_ok[0] = (oy_y >= YW'(2)) && (oy_y + YW'(1) <= h_y);
    win_d.row_ok[1] = (oy_y >= YW'(1)) && (oy_y + YW'(2) <= h_y);
    win_d.row_ok[2] = (oy_y + YW'(3) <= h_y);

    // With a single pending pixel its entry in the line memory is not yet complete.
    win_d.bypass    = (p_x == XW'(1));
    win_d.byp_own   = hist_q[0];
    win_d.byp_left  = hist_q[1];
    win_d.byp_color = color_last_q;
    win_d.frame_end = (ox_x == w_x - XW'(1)) && (oy_y == h_y - YW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      cnt_q    <= '0;
      ox_q     <= '0;
      oy_q     <= '0;
    end else begin
      cnt_q <= cnt_d;
      ox_q  <= ox_d;
      oy_q  <= oy_d;
      if (accept && is_pixel) begin
        wr_ptr_q <= wr_ptr_q + TAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_pixel) begin
      hist_q       <= {hist_q[1:0], raw_new};
      color_last_q <= s_axis_tdata;
    end
    if (accept && emit) begin
      s1_win_q <= win_d;
    end
  end

  // Line memories. Entry k of the current-line memory holds the color of pixel
  // k-1 and the raw bits of pixels k, k-1, k-2; the previous-line memory holds
  // the same three raw bits. Reading both one place after the oldest pending
  // pixel, and one line further back, gives the middle and top window rows.
  logic [TAW-1:0] old_ptr, t_raddr;
  logic [AAW-1:0] a_raddr;
  logic           ram_re, ram_we;
  logic [A_W-1:0] a_rdata;
  logic [2:0]     t_rdata;

  assign old_ptr = wr_ptr_q - TAW'(cnt_q);
  assign a_raddr = AAW'(old_ptr + TAW'(1));
  assign t_raddr = old_ptr + TAW'(1) - TAW'(width_q);
  assign ram_re  = accept && emit;
  assign ram_we  = accept && is_pixel;

  cmdim_ram #(
    .WIDTH (A_W),
    .DEPTH (A_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q[AAW-1:0]),
    .wdata_i ({color_last_q, raw_new, hist_q[0], hist_q[1]}),
    .re_i    (ram_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  cmdim_ram #(
    .WIDTH (3),
    .DEPTH (T_DEPTH)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i ({raw_new, hist_q[0], hist_q[1]}),
    .re_i    (ram_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  // Evaluation stage: dilate and dim.
  logic [2:0]       mid;
  logic [RGB_W-1:0] s1_color;
  logic             s1_hit;
  logic [RGB_W-1:0] s1_pixel;

  always_comb begin
    mid      = s1_win_q.bypass ? {1'b0, s1_win_q.byp_own, s1_win_q.byp_left} : a_rdata[2:0];
    s1_color = s1_win_q.bypass ? s1_win_q.byp_color : a_rdata[A_W-1:3];
    s1_hit   = mid[1] ||
               (|(t_rdata      & s1_win_q.col_ok & {3{s1_win_q.row_ok[0]}})) ||
               (|(mid          & s1_win_q.col_ok & {3{s1_win_q.row_ok[1]}})) ||
               (|(s1_win_q.bot & s1_win_q.col_ok & {3{s1_win_q.row_ok[2]}}));
    if (s1_hit) begin
      s1_pixel = s1_color;
    end else begin
      s1_pixel = {dim_chan(s1_color[3*CHAN_W-1:2*CHAN_W]),
                  dim_chan(s1_color[2*CHAN_W-1:CHAN_W]),
                  dim_chan(s1_color[CHAN_W-1:0])};
    end
  end

  // Output register.
  logic [RGB_W-1:0] out_data_q;
  logic             out_mask_q, out_last_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept && emit) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_data_q <= s1_pixel;
      out_mask_q <= s1_hit;
      out_last_q <= s1_win_q.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_mask_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the color mask, 3x3 dilation and dimming pixel block.

localparam int MAX_DIM   = 1024;
localparam int RING_SIZE = 2 * MAX_DIM + 3;

typedef struct {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       in_mask;
  logic       frame_end;
} pixel_out_t;

// Keeps its own copy of the block state, predicts each delayed pixel and checks it.
class mask_dim_checker;
  logic [23:0] ring_rgb [RING_SIZE];
  bit          ring_fruit [RING_SIZE];
  int          wr_pos;
  int          backlog;
  int          in_col, in_row, out_col, out_row;
  int          frame_w_reg, frame_h_reg, red_floor, green_floor;
  pixel_out_t  expected_pixels[$];
  int          mismatches;

  function new();
    foreach (ring_rgb[i]) begin
      ring_rgb[i]   = '0;
      ring_fruit[i] = 1'b0;
    end
    wr_pos      = 0;
    backlog     = 0;
    in_col      = 0;
    in_row      = 0;
    out_col     = 0;
    out_row     = 0;
    frame_w_reg = cmdim_pkg::FRAME_WIDTH_RST;
    frame_h_reg = cmdim_pkg::FRAME_HEIGHT_RST;
    red_floor   = cmdim_pkg::RED_FLOOR_RST;
    green_floor = cmdim_pkg::GREEN_FLOOR_RST;
    mismatches  = 0;
  endfunction

  function void set_register(cmdim_pkg::cfg_idx_e idx, logic [10:0] value);
    case (idx)
      cmdim_pkg::CFG_FRAME_WIDTH:  frame_w_reg = value;
      cmdim_pkg::CFG_FRAME_HEIGHT: frame_h_reg = value;
      cmdim_pkg::CFG_RED_FLOOR:    red_floor   = value[7:0];
      cmdim_pkg::CFG_GREEN_FLOOR:  green_floor = value[7:0];
      default: ;
    endcase
  endfunction

  // Out-of-range sizes are clamped to 1 .. MAX_DIM.
  function int eff_w();
    return (frame_w_reg < 1) ? 1 : (frame_w_reg > MAX_DIM) ? MAX_DIM : frame_w_reg;
  endfunction

  function int eff_h();
    return (frame_h_reg < 1) ? 1 : (frame_h_reg > MAX_DIM) ? MAX_DIM : frame_h_reg;
  endfunction

  function logic [7:0] dim(logic [7:0] c);
    return 8'((3 * int'(c)) / 10);
  endfunction

  // Sends the oldest waiting pixel: its own bit, or any set interior neighbor that has
  // already arrived, puts it in the mask.
  function void release_oldest();
    int          w, h, old, ahead, nx, ny, ofs;
    bit          m;
    logic [23:0] c;
    pixel_out_t  p;
    w     = eff_w();
    h     = eff_h();
    old   = (wr_pos + RING_SIZE - backlog) % RING_SIZE;
    ahead = backlog - 1;
    m     = ring_fruit[old];
    c     = ring_rgb[old];
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        nx  = out_col + dx;
        ny  = out_row + dy;
        ofs = dy * w + dx;
        if (nx >= 1 && nx <= w - 2 && ny >= 1 && ny <= h - 2 && ofs <= ahead) begin
          if (ring_fruit[(old + RING_SIZE + ofs) % RING_SIZE]) m = 1'b1;
        end
      end
    end
    p.red       = m ? c[7:0]   : dim(c[7:0]);
    p.green     = m ? c[15:8]  : dim(c[15:8]);
    p.blue      = m ? c[23:16] : dim(c[23:16]);
    p.in_mask   = m;
    p.frame_end = (out_col == w - 1 && out_row == h - 1);
    expected_pixels.push_back(p);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
    backlog--;
  endfunction

  function void take_item(cmdim_pkg::op_e op, logic [23:0] rgb);
    int r, g, b;
    bit red_ok, green_ok;
    if (op == cmdim_pkg::OP_DRAIN) begin
      if (backlog > 0) release_oldest();
      return;
    end
    r        = rgb[7:0];
    g        = rgb[15:8];
    b        = rgb[23:16];
    red_ok   = (2 * r > 3 * g) && (2 * r > 3 * b) && (r > red_floor);
    green_ok = (5 * g > 6 * r) && (5 * g > 6 * b) && (g > green_floor);
    ring_rgb[wr_pos]   = rgb;
    ring_fruit[wr_pos] = red_ok || green_ok;
    wr_pos  = (wr_pos + 1) % RING_SIZE;
    backlog++;
    in_col++;
    if (in_col >= eff_w()) begin
      in_col = 0;
      in_row++;
      if (in_row >= eff_h()) in_row = 0;
    end
    if (backlog > eff_w() + 1) release_oldest();
  endfunction

  task report(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task check_pixel(logic [23:0] rgb, logic mask, logic last);
    pixel_out_t p;
    if (expected_pixels.size() == 0) begin
      report($sformatf("pixel %h with no pixel expected", rgb));
      return;
    end
    p = expected_pixels.pop_front();
    if (rgb[7:0] !== p.red)
      report($sformatf("red got %0d want %0d", rgb[7:0], p.red));
    if (rgb[15:8] !== p.green)
      report($sformatf("green got %0d want %0d", rgb[15:8], p.green));
    if (rgb[23:16] !== p.blue)
      report($sformatf("blue got %0d want %0d", rgb[23:16], p.blue));
    if (mask !== p.in_mask)
      report($sformatf("in_mask got %b want %b", mask, p.in_mask));
    if (last !== p.frame_end)
      report($sformatf("frame_end got %b want %b", last, p.frame_end));
  endtask

  function int outstanding();
    return expected_pixels.size();
  endfunction
endclass

module testbench;
  import cmdim_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PIXELS = 450;
  localparam int EDGE_PIXELS   = 32;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i    = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [RGB_W-1:0]     s_axis_tdata  = '0;   // red, green, blue
  logic                 s_axis_tuser  = 1'b0; // op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [RGB_W-1:0]     m_axis_tdata;         // out_red, out_green, out_blue
  logic                 m_axis_tuser;         // in_mask
  logic                 m_axis_tlast;         // frame_end

  mask_dim_checker board;
  int unsigned     cycles = 0;
  int              random_pixels = 0;
  bit              steady_feed = 1'b0;

  color_mask_dilate_dim_pixels dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // A hung pipeline or a lost pixel ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Outputs are sampled at the rising edge, before the block updates its registers.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_pixel(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  function automatic logic [23:0] pack_rgb(int r, int g, int b);
    return {8'(b), 8'(g), 8'(r)};
  endfunction

  // Most gaps and stalls are short or absent; a few run longer.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // Fruit-like pixels sit close to the test thresholds at their upper end, gray
  // pixels (red equal to green) can never pass, and the rest are fully random.
  function automatic logic [23:0] random_pixel(int fruit_pct);
    int r, g, b;
    if ($urandom_range(0, 99) < fruit_pct) begin
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(60, 255);
        g = $urandom_range(0, (2 * r) / 3);
        b = $urandom_range(0, (2 * r) / 3);
      end else begin
        g = $urandom_range(60, 255);
        r = $urandom_range(0, (5 * g) / 6);
        b = $urandom_range(0, (5 * g) / 6);
      end
    end else if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
    end else begin
      r = $urandom_range(0, 255);
      g = r;
      b = $urandom_range(0, 255);
    end
    return pack_rgb(r, g, b);
  endfunction

  function automatic int pick_floor();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  // Offers one item and returns once it has been accepted. Valid stays high when the
  // next item follows without a gap; during a gap the data lines carry noise.
  task automatic send_item(op_e op, logic [23:0] rgb);
    int gap;
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 24'($urandom);
      s_axis_tuser  <= 1'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rgb;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_item(op, rgb);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [10:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    board.set_register(idx, value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic configure(int w, int h, int red_fl, int green_fl);
    write_register(CFG_FRAME_WIDTH, 11'(w));
    write_register(CFG_FRAME_HEIGHT, 11'(h));
    write_register(CFG_RED_FLOOR, 11'(red_fl));
    write_register(CFG_GREEN_FLOOR, 11'(green_fl));
  endtask

  // Pushes every waiting pixel out, then a few drains that find nothing to send.
  task automatic flush_backlog();
    int extra;
    extra = $urandom_range(0, 2);
    while (board.backlog > 0) send_item(OP_DRAIN, 24'($urandom));
    repeat (extra) send_item(OP_DRAIN, 24'($urandom));
  endtask

  // Waits until every expected pixel has come out. Drains with nothing waiting and
  // pixels still filling the line produce no result, so the task keeps waiting after
  // that to cover the two-stage pipeline before the configuration may change.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Whole frames keep every configuration change on a frame boundary, so no window
  // ever reaches a line store entry that has not been written since reset.
  task automatic run_frames(int frames, int fruit_pct, int drain_pct);
    int area;
    area = board.eff_w() * board.eff_h();
    repeat (frames) begin
      for (int i = 0; i < area; i++) begin
        if ($urandom_range(0, 99) < drain_pct) send_item(OP_DRAIN, 24'($urandom));
        send_item(OP_PIXEL, random_pixel(fruit_pct));
        random_pixels++;
      end
    end
    flush_backlog();
    settle();
  endtask

  // Directed 4x4 frame with the floors left at their reset values. The interior
  // pixels at row 1, column 1 and at row 2, column 1 spread their bit; border pixels
  // keep theirs.
  task automatic directed_frame();
    logic [23:0] probes [16];
    probes[0]  = pack_rgb(0, 0, 0);
    probes[1]  = pack_rgb(255, 255, 255);
    probes[2]  = pack_rgb(255, 0, 0);       // strongest red on the border
    probes[3]  = pack_rgb(0, 255, 0);
    probes[4]  = pack_rgb(0, 0, 255);
    probes[5]  = pack_rgb(101, 67, 67);     // red test passes by one on every compare
    probes[6]  = pack_rgb(100, 10, 10);     // red equal to its floor fails
    probes[7]  = pack_rgb(151, 100, 100);   // red on the border, keeps its own bit
    probes[8]  = pack_rgb(150, 100, 100);   // 2r equals 3g, fails
    probes[9]  = pack_rgb(100, 121, 100);   // green test passes by one
    probes[10] = pack_rgb(100, 120, 100);   // 5g equals 6r, fails
    probes[11] = pack_rgb(0, 81, 0);        // green just above its floor
    probes[12] = pack_rgb(0, 80, 0);        // green equal to its floor fails
    probes[13] = pack_rgb(128, 128, 128);
    probes[14] = pack_rgb(1, 2, 3);
    probes[15] = pack_rgb(254, 253, 252);
    write_register(CFG_FRAME_WIDTH, 11'd4);
    write_register(CFG_FRAME_HEIGHT, 11'd4);
    // A drain with nothing waiting must produce no item.
    send_item(OP_DRAIN, 24'hFFFFFF);
    for (int i = 0; i < 16; i++) begin
      send_item(OP_PIXEL, probes[i]);
      // A drain in the middle of the frame sends one pixel early, with the pixels
      // not yet received counting as background in its window.
      if (i == 7) send_item(OP_DRAIN, 24'h000000);
    end
    flush_backlog();
    send_item(OP_DRAIN, 24'h5A5A5A);
    settle();
  endtask

  // The receiver alternates ready runs, some of them long, with random stalls.
  initial begin
    int ready_run;
    int stall;
    @(posedge rst_ni);
    forever begin
      ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      repeat (ready_run) @(negedge clk_i) m_axis_tready <= 1'b1;
      stall = pick_gap();
      repeat (stall) @(negedge clk_i) m_axis_tready <= 1'b0;
    end
  end

  initial begin
    board = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_frame();

    // Random small frames, narrow ones included, with random floors and fruit density.
    while (random_pixels < RANDOM_PIXELS) begin
      configure($urandom_range(0, 12), $urandom_range(0, 8), pick_floor(), pick_floor());
      steady_feed = ($urandom_range(0, 3) == 0);
      run_frames($urandom_range(1, 3), $urandom_range(0, 60), $urandom_range(0, 8));
    end

    // Size extremes come last, on a part of a frame each: a width above the maximum
    // clamps to MAX_DIM with a height of zero acting as one, then the transposed case.
    // The output position carries over into the second size and wraps against it.
    configure(2047, 0, 0, 255);
    repeat (EDGE_PIXELS) send_item(OP_PIXEL, random_pixel(30));
    flush_backlog();
    settle();
    configure(0, 2047, 255, 0);
    repeat (EDGE_PIXELS) send_item(OP_PIXEL, random_pixel(30));
    flush_backlog();
    settle();

    if (board.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
